// ----- design/i2c_bitbang_master_assert.svh -----
// Assertion macros for the I2C bit engine checker.
`ifndef I2C_BITBANG_MASTER_ASSERT_SVH
`define I2C_BITBANG_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define I2CBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define I2CBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/i2cbb_pkg.sv -----
// Types and constants shared by the I2C bit engine modules.
`timescale 1ns / 1ps
package i2cbb_pkg;

  localparam int unsigned PhaseW = 16;
  localparam int unsigned TmoW   = 8;
  localparam int unsigned BitW   = 4;

  localparam logic [PhaseW-1:0] PHASE_TICKS_RESET = 16'd250;
  localparam logic [TmoW-1:0]   ACK_TIMEOUT_RESET = 8'd250;

  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_STOP     = 3'd1;
  localparam logic [2:0] CMD_WRITE    = 3'd2;
  localparam logic [2:0] CMD_WAIT_ACK = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;

  // One classified tick as it travels from front to back.
  typedef struct packed {
    logic       cmd_ok;
    logic [2:0] command;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase_ticks;
    logic [TmoW-1:0]   ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } pins_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } res_t;

  typedef enum logic [15:0] {
    PH_IDLE = 16'h0001,
    PH_ST_A = 16'h0002,
    PH_ST_B = 16'h0004,
    PH_ST_C = 16'h0008,
    PH_SP_A = 16'h0010,
    PH_SP_B = 16'h0020,
    PH_SP_C = 16'h0040,
    PH_WR_A = 16'h0080,
    PH_WR_B = 16'h0100,
    PH_WR_C = 16'h0200,
    PH_AK_A = 16'h0400,
    PH_AK_B = 16'h0800,
    PH_RD_A = 16'h1000,
    PH_RD_B = 16'h2000,
    PH_NK_A = 16'h4000,
    PH_NK_B = 16'h8000
  } phase_e;

endpackage

// ----- design/i2cbb_front.sv -----
// Front end: accepts ticks, classifies the command and queues them for the engine.
`timescale 1ns / 1ps
module i2cbb_front #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_valid_i,
  input  logic [2:0]        command_i,
  input  logic [7:0]        write_data_i,
  input  logic              send_ack_i,
  input  logic              sda_in_i,
  input  logic              pop_i,
  output logic              q_valid_o,
  output i2cbb_pkg::tick_t  q_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2cbb_pkg::tick_t  slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;
  i2cbb_pkg::tick_t  tick;

  // Codes above read are marked not ok here, so the engine treats them as no command.
  always_comb begin
    tick.cmd_ok     = cmd_valid_i && (command_i <= i2cbb_pkg::CMD_READ);
    tick.command    = command_i;
    tick.write_data = write_data_i;
    tick.send_ack   = send_ack_i;
    tick.sda_in     = sda_in_i;
  end

  assign in_ready_o = (cnt_q != CntW'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= tick;
    end
  end

endmodule

// ----- design/i2cbb_engine.sv -----
// Back end: bit engine; one tick per cycle into an output register while unstalled.
`timescale 1ns / 1ps
module i2cbb_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  i2cbb_pkg::cfg_t   cfg_i,
  input  logic              q_valid_i,
  input  i2cbb_pkg::tick_t  q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2cbb_pkg::res_t   res_o
);

  i2cbb_pkg::phase_e                 phase_q, phase_d;
  logic [i2cbb_pkg::BitW-1:0]        bit_q, bit_d, bit_inc;
  logic [7:0]                        shift_q, shift_d;
  logic [i2cbb_pkg::PhaseW-1:0]      pc_q, pc_d, pc_inc, n_eff;
  logic [i2cbb_pkg::TmoW-1:0]        tmo_q, tmo_d;
  i2cbb_pkg::pins_t                  pins_q, pins_d;
  logic                              err_q, err_d;
  logic                              ack_q, ack_d;
  logic [7:0]                        rdata_q, rdata_d;
  logic                              done;
  logic                              over;
  logic                              adv;
  logic                              out_valid_q;
  i2cbb_pkg::res_t                   res_q, res_d;

  function automatic i2cbb_pkg::pins_t mk_pins(input logic scl, input logic sda,
                                               input logic drv);
    i2cbb_pkg::pins_t p;
    p.scl = scl;
    p.sda = sda;
    p.drv = drv;
    return p;
  endfunction

  // Take the next tick whenever the output register is free or being drained.
  assign adv         = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = adv;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign n_eff   = (cfg_i.phase_ticks == '0) ? i2cbb_pkg::PhaseW'(1) : cfg_i.phase_ticks;
  assign pc_inc  = pc_q + 1'b1;
  assign over    = (pc_inc >= n_eff);
  assign bit_inc = bit_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pc_d    = pc_q;
    tmo_d   = tmo_q;
    pins_d  = pins_q;
    err_d   = err_q;
    ack_d   = ack_q;
    rdata_d = rdata_q;
    done    = 1'b0;

    case (phase_q)
      i2cbb_pkg::PH_IDLE: begin
        if (q_data_i.cmd_ok) begin
          bit_d = '0;
          pc_d  = '0;
          case (q_data_i.command)
            i2cbb_pkg::CMD_START: begin
              phase_d = i2cbb_pkg::PH_ST_A;
              pins_d  = mk_pins(1'b1, 1'b1, 1'b1);
            end
            i2cbb_pkg::CMD_STOP: begin
              phase_d = i2cbb_pkg::PH_SP_A;
              pins_d  = mk_pins(1'b0, 1'b0, 1'b1);
            end
            i2cbb_pkg::CMD_WRITE: begin
              shift_d = q_data_i.write_data;
              phase_d = i2cbb_pkg::PH_WR_A;
              pins_d  = mk_pins(1'b0, q_data_i.write_data[7], 1'b1);
            end
            i2cbb_pkg::CMD_WAIT_ACK: begin
              err_d   = 1'b0;
              tmo_d   = '0;
              phase_d = i2cbb_pkg::PH_AK_A;
              pins_d  = mk_pins(1'b0, 1'b1, 1'b0);
            end
            default: begin
              ack_d   = q_data_i.send_ack;
              shift_d = '0;
              phase_d = i2cbb_pkg::PH_RD_A;
              pins_d  = mk_pins(1'b0, 1'b1, 1'b0);
            end
          endcase
        end
      end
      i2cbb_pkg::PH_AK_B: begin
        // Poll every tick; a low SDA is the acknowledge.
        if (!q_data_i.sda_in) begin
          pins_d.scl = 1'b0;
          phase_d    = i2cbb_pkg::PH_IDLE;
          done       = 1'b1;
        end else if (tmo_q == cfg_i.ack_timeout) begin
          err_d   = 1'b1;
          phase_d = i2cbb_pkg::PH_SP_A;
          pins_d  = mk_pins(1'b0, 1'b0, 1'b1);
          pc_d    = '0;
        end else begin
          tmo_d = tmo_q + 1'b1;
        end
      end
      default: begin
        pc_d = pc_inc;
        if (over) begin
          pc_d = '0;
          case (phase_q)
            i2cbb_pkg::PH_ST_A: begin
              phase_d = i2cbb_pkg::PH_ST_B;
              pins_d  = mk_pins(1'b1, 1'b0, 1'b1);
            end
            i2cbb_pkg::PH_ST_B: begin
              phase_d = i2cbb_pkg::PH_ST_C;
              pins_d  = mk_pins(1'b0, 1'b0, 1'b1);
            end
            i2cbb_pkg::PH_SP_A: begin
              phase_d = i2cbb_pkg::PH_SP_B;
              pins_d  = mk_pins(1'b1, 1'b0, 1'b1);
            end
            i2cbb_pkg::PH_SP_B: begin
              phase_d = i2cbb_pkg::PH_SP_C;
              pins_d  = mk_pins(1'b1, 1'b1, 1'b1);
            end
            i2cbb_pkg::PH_WR_A: begin
              phase_d = i2cbb_pkg::PH_WR_B;
              pins_d  = mk_pins(1'b1, pins_q.sda, 1'b1);
            end
            i2cbb_pkg::PH_WR_B: begin
              phase_d = i2cbb_pkg::PH_WR_C;
              pins_d  = mk_pins(1'b0, pins_q.sda, 1'b1);
            end
            i2cbb_pkg::PH_WR_C: begin
              bit_d   = bit_inc;
              shift_d = {shift_q[6:0], 1'b0};
              if (bit_inc[3]) begin
                phase_d = i2cbb_pkg::PH_IDLE;
                done    = 1'b1;
              end else begin
                phase_d = i2cbb_pkg::PH_WR_A;
                pins_d  = mk_pins(1'b0, shift_q[6], 1'b1);
              end
            end
            i2cbb_pkg::PH_AK_A: begin
              phase_d = i2cbb_pkg::PH_AK_B;
              pins_d  = mk_pins(1'b1, 1'b1, 1'b0);
            end
            i2cbb_pkg::PH_RD_A: begin
              phase_d = i2cbb_pkg::PH_RD_B;
              pins_d  = mk_pins(1'b1, 1'b1, 1'b0);
            end
            i2cbb_pkg::PH_RD_B: begin
              // Sample SDA as the high half of the clock ends.
              shift_d = {shift_q[6:0], q_data_i.sda_in};
              rdata_d = {shift_q[6:0], q_data_i.sda_in};
              bit_d   = bit_inc;
              if (bit_inc[3]) begin
                phase_d = i2cbb_pkg::PH_NK_A;
                pins_d  = mk_pins(1'b0, !ack_q, 1'b1);
              end else begin
                phase_d = i2cbb_pkg::PH_RD_A;
                pins_d  = mk_pins(1'b0, 1'b1, 1'b0);
              end
            end
            i2cbb_pkg::PH_NK_A: begin
              phase_d = i2cbb_pkg::PH_NK_B;
              pins_d  = mk_pins(1'b1, pins_q.sda, 1'b1);
            end
            default: begin
              // End of start, stop or acknowledge send.
              if (phase_q == i2cbb_pkg::PH_NK_B) begin
                pins_d.scl = 1'b0;
              end
              phase_d = i2cbb_pkg::PH_IDLE;
              done    = 1'b1;
            end
          endcase
        end
      end
    endcase

    res_d.scl_out   = pins_d.scl;
    res_d.sda_out   = pins_d.sda;
    res_d.sda_drive = pins_d.drv;
    res_d.busy_res  = (phase_d != i2cbb_pkg::PH_IDLE);
    res_d.done_res  = done;
    res_d.read_data = rdata_d;
    res_d.ack_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cbb_pkg::PH_IDLE;
      bit_q       <= '0;
      shift_q     <= '0;
      pc_q        <= '0;
      tmo_q       <= '0;
      pins_q      <= mk_pins(1'b1, 1'b1, 1'b1);
      err_q       <= 1'b0;
      ack_q       <= 1'b0;
      rdata_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        phase_q     <= phase_d;
        bit_q       <= bit_d;
        shift_q     <= shift_d;
        pc_q        <= pc_d;
        tmo_q       <= tmo_d;
        pins_q      <= pins_d;
        err_q       <= err_d;
        ack_q       <= ack_d;
        rdata_q     <= rdata_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

endmodule

// ----- design/i2c_bitbang_master.sv -----
// Top level of the tick-driven I2C master bit engine with its register port.
//
//   channel   dir  handshake                 beat
//   in        in   in_valid_i / in_ready_o   one tick: cmd_valid, command, write_data,
//                                            send_ack, sda_in
//   out       out  out_valid_o / out_ready_i one result per tick: pins, busy, done,
//                                            read_data, ack_error
//   cfg       in   psel/penable/pwrite       phase_ticks at 0x0, ack_timeout at 0x4
//
// One tick per clock cycle sustained while the output is not stalled; an accepted tick is
// written into the queue, then the engine takes it and writes its output register.
// The tick queue holds QueueDepth beats, so input keeps flowing while a result waits.
// Reset leaves the engine's pin state driven high, the engine idle and both registers at 250.
// A stalled output holds the engine; the queue fills, then in_ready_o drops.
`timescale 1ns / 1ps
module i2c_bitbang_master #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_valid_i,
  input  logic [2:0]  command_i,
  input  logic [7:0]  write_data_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_data_o,
  output logic        ack_error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  i2cbb_pkg::cfg_t  cfg_q;
  logic             cfg_wr;
  logic             pop;
  logic             q_valid;
  i2cbb_pkg::tick_t q_data;
  i2cbb_pkg::res_t  res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks <= i2cbb_pkg::PHASE_TICKS_RESET;
      cfg_q.ack_timeout <= i2cbb_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PHASE_TICKS: cfg_q.phase_ticks <= pwdata[i2cbb_pkg::PhaseW-1:0];
        REG_ACK_TIMEOUT: cfg_q.ack_timeout <= pwdata[i2cbb_pkg::TmoW-1:0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PHASE_TICKS: prdata = {16'd0, cfg_q.phase_ticks};
      REG_ACK_TIMEOUT: prdata = {24'd0, cfg_q.ack_timeout};
      default:         prdata = '0;
    endcase
  end

  i2cbb_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_valid_i  (cmd_valid_i),
    .command_i    (command_i),
    .write_data_i (write_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .pop_i        (pop),
    .q_valid_o    (q_valid),
    .q_data_o     (q_data)
  );

  i2cbb_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign scl_out_o   = res.scl_out;
  assign sda_out_o   = res.sda_out;
  assign sda_drive_o = res.sda_drive;
  assign busy_res_o  = res.busy_res;
  assign done_res_o  = res.done_res;
  assign read_data_o = res.read_data;
  assign ack_error_o = res.ack_error;

endmodule

// ----- design/i2cbb_checker.sv -----
// Port-level checker for the I2C bit engine and its bind to the top level.
`timescale 1ns / 1ps
`include "i2c_bitbang_master_assert.svh"
module i2cbb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic sda_out_o,
  input logic sda_drive_o,
  input logic busy_res_o,
  input logic done_res_o
);

  `I2CBB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped while stalled")
  `I2CBB_ASSERT_NOW(a_done_idle, out_valid_o && done_res_o, !busy_res_o, "done beat still busy")
  `I2CBB_ASSERT_NOW(a_release_high, out_valid_o && !sda_drive_o, sda_out_o, "released SDA not high")
  `I2CBB_ASSERT_NOW(a_full_stalled, !in_ready_o, out_valid_o, "queue full without pending result")

endmodule

bind i2c_bitbang_master i2cbb_checker u_i2cbb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sda_out_o   (sda_out_o),
  .sda_drive_o (sda_drive_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o)
);

// ----- dv/i2c_bitbang_master_tb.sv -----
// Self-checking testbench for the tick-driven I2C master bit engine.
`timescale 1ns / 1ps
module i2c_bitbang_master_tb;

  localparam logic [2:0] ADDR_PHASE_TICKS = 3'h0;
  localparam logic [2:0] ADDR_ACK_TIMEOUT = 3'h4;
  localparam int         CmdCodeMax       = 7;
  localparam int         RandTicks        = 300;
  localparam int         ReadyHoldCycles  = 60;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] command;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } tick_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_valid_i;
  logic [2:0]  command_i;
  logic [7:0]  write_data_i;
  logic        send_ack_i;
  logic        sda_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        sda_drive_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  read_data_o;
  logic        ack_error_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2c_bitbang_master uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_valid_i  (cmd_valid_i),
    .command_i    (command_i),
    .write_data_i (write_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_out_o    (scl_out_o),
    .sda_out_o    (sda_out_o),
    .sda_drive_o  (sda_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_data_o  (read_data_o),
    .ack_error_o  (ack_error_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Engine state as predicted from the accepted ticks.
  logic [15:0]         cfg_phase_ticks;
  logic [7:0]          cfg_ack_timeout;
  i2cbb_pkg::phase_e   eng_phase;
  logic [3:0]          bit_idx;
  logic [7:0]          shift_q;
  logic [15:0]         phase_cnt;
  logic [7:0]          wait_cnt;
  logic                pin_scl, pin_sda, pin_drv;
  logic                ack_err;
  logic                ack_pick;
  logic [7:0]          rx_byte;

  i2cbb_pkg::res_t pending_res[$];
  int   err_count  = 0;
  int   ticks_sent = 0;
  bit   idle_on    = 1'b1;
  int   hold_len   = 0;
  int   stall_left = 0;

  function automatic void go_phase(i2cbb_pkg::phase_e p, logic scl, logic sda, logic drv);
    eng_phase = p;
    pin_scl   = scl;
    pin_sda   = sda;
    pin_drv   = drv;
    phase_cnt = '0;
  endfunction

  function automatic i2cbb_pkg::res_t engine_tick(tick_beat_t t);
    logic [15:0]     span;
    logic            fin;
    i2cbb_pkg::res_t r;
    span = (cfg_phase_ticks == '0) ? 16'd1 : cfg_phase_ticks;
    fin  = 1'b0;
    if (eng_phase == i2cbb_pkg::PH_IDLE) begin
      if (t.cmd_valid && t.command <= i2cbb_pkg::CMD_READ) begin
        bit_idx = '0;
        case (t.command)
          i2cbb_pkg::CMD_START: go_phase(i2cbb_pkg::PH_ST_A, 1'b1, 1'b1, 1'b1);
          i2cbb_pkg::CMD_STOP:  go_phase(i2cbb_pkg::PH_SP_A, 1'b0, 1'b0, 1'b1);
          i2cbb_pkg::CMD_WRITE: begin
            shift_q = t.write_data;
            go_phase(i2cbb_pkg::PH_WR_A, 1'b0, shift_q[7], 1'b1);
          end
          i2cbb_pkg::CMD_WAIT_ACK: begin
            ack_err  = 1'b0;
            wait_cnt = '0;
            go_phase(i2cbb_pkg::PH_AK_A, 1'b0, 1'b1, 1'b0);
          end
          default: begin
            ack_pick = t.send_ack;
            shift_q  = '0;
            go_phase(i2cbb_pkg::PH_RD_A, 1'b0, 1'b1, 1'b0);
          end
        endcase
      end
    end else if (eng_phase == i2cbb_pkg::PH_AK_B) begin
      if (!t.sda_in) begin
        pin_scl   = 1'b0;
        eng_phase = i2cbb_pkg::PH_IDLE;
        fin       = 1'b1;
      end else if (wait_cnt == cfg_ack_timeout) begin
        ack_err = 1'b1;
        go_phase(i2cbb_pkg::PH_SP_A, 1'b0, 1'b0, 1'b1);
      end else begin
        wait_cnt = wait_cnt + 8'd1;
      end
    end else begin
      phase_cnt = phase_cnt + 16'd1;
      if (phase_cnt >= span) begin
        case (eng_phase)
          i2cbb_pkg::PH_ST_A: go_phase(i2cbb_pkg::PH_ST_B, 1'b1, 1'b0, 1'b1);
          i2cbb_pkg::PH_ST_B: go_phase(i2cbb_pkg::PH_ST_C, 1'b0, 1'b0, 1'b1);
          i2cbb_pkg::PH_SP_A: go_phase(i2cbb_pkg::PH_SP_B, 1'b1, 1'b0, 1'b1);
          i2cbb_pkg::PH_SP_B: go_phase(i2cbb_pkg::PH_SP_C, 1'b1, 1'b1, 1'b1);
          i2cbb_pkg::PH_WR_A: go_phase(i2cbb_pkg::PH_WR_B, 1'b1, pin_sda, 1'b1);
          i2cbb_pkg::PH_WR_B: go_phase(i2cbb_pkg::PH_WR_C, 1'b0, pin_sda, 1'b1);
          i2cbb_pkg::PH_WR_C: begin
            bit_idx = bit_idx + 4'd1;
            shift_q = shift_q << 1;
            if (bit_idx >= 4'd8) begin
              eng_phase = i2cbb_pkg::PH_IDLE;
              fin       = 1'b1;
            end else begin
              go_phase(i2cbb_pkg::PH_WR_A, 1'b0, shift_q[7], 1'b1);
            end
          end
          i2cbb_pkg::PH_AK_A: go_phase(i2cbb_pkg::PH_AK_B, 1'b1, 1'b1, 1'b0);
          i2cbb_pkg::PH_RD_A: go_phase(i2cbb_pkg::PH_RD_B, 1'b1, 1'b1, 1'b0);
          i2cbb_pkg::PH_RD_B: begin
            // sample SDA at the end of the high step
            shift_q = {shift_q[6:0], t.sda_in};
            rx_byte = shift_q;
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= 4'd8) go_phase(i2cbb_pkg::PH_NK_A, 1'b0, !ack_pick, 1'b1);
            else go_phase(i2cbb_pkg::PH_RD_A, 1'b0, 1'b1, 1'b0);
          end
          i2cbb_pkg::PH_NK_A: go_phase(i2cbb_pkg::PH_NK_B, 1'b1, pin_sda, 1'b1);
          default: begin
            if (eng_phase == i2cbb_pkg::PH_NK_B) pin_scl = 1'b0;
            eng_phase = i2cbb_pkg::PH_IDLE;
            phase_cnt = '0;
            fin       = 1'b1;
          end
        endcase
      end
    end
    r.scl_out   = pin_scl;
    r.sda_out   = pin_sda;
    r.sda_drive = pin_drv;
    r.busy_res  = (eng_phase != i2cbb_pkg::PH_IDLE);
    r.done_res  = fin;
    r.read_data = rx_byte;
    r.ack_error = ack_err;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic tick_beat_t rand_tick();
    tick_beat_t t;
    t.cmd_valid  = ($urandom_range(0, 3) == 0);
    t.command    = 3'($urandom_range(0, CmdCodeMax));
    t.write_data = 8'($urandom_range(0, 255));
    t.send_ack   = 1'($urandom_range(0, 1));
    t.sda_in     = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_tick(tick_beat_t t);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    cmd_valid_i  = t.cmd_valid;
    command_i    = t.command;
    write_data_i = t.write_data;
    send_ack_i   = t.send_ack;
    sda_in_i     = t.sda_in;
    do @(posedge clk_i); while (!in_ready_o);
    pending_res.push_back(engine_tick(t));
    ticks_sent++;
  endtask

  // Offer one command, then tick until the engine is idle again. In the ack
  // poll, hold SDA high for ack_after ticks, then pull it low.
  task automatic issue(logic [2:0] cmd, logic [7:0] wdata, logic sack, int ack_after,
                       bit noisy);
    tick_beat_t t;
    int         high_ticks;
    t            = rand_tick();
    t.cmd_valid  = 1'b1;
    t.command    = cmd;
    t.write_data = wdata;
    t.send_ack   = sack;
    send_tick(t);
    high_ticks = 0;
    while (eng_phase != i2cbb_pkg::PH_IDLE) begin
      t = rand_tick();
      if (!noisy) t.cmd_valid = 1'b0;
      if (eng_phase == i2cbb_pkg::PH_AK_B) begin
        t.sda_in = (high_ticks < ack_after);
        high_ticks++;
      end
      send_tick(t);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_PHASE_TICKS) cfg_phase_ticks = value[15:0];
    else if (addr == ADDR_ACK_TIMEOUT) cfg_ack_timeout = value[7:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_timing(logic [15:0] ticks, logic [7:0] tmo);
    wait_drained();
    cfg_write(ADDR_PHASE_TICKS, {16'h0, ticks});
    cfg_write(ADDR_ACK_TIMEOUT, {24'h0, tmo});
  endtask

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    i2cbb_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_res.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        want = pending_res.pop_front();
        check_field("scl_out", 8'(want.scl_out), 8'(scl_out_o));
        check_field("sda_out", 8'(want.sda_out), 8'(sda_out_o));
        check_field("sda_drive", 8'(want.sda_drive), 8'(sda_drive_o));
        check_field("busy_res", 8'(want.busy_res), 8'(busy_res_o));
        check_field("done_res", 8'(want.done_res), 8'(done_res_o));
        check_field("read_data", want.read_data, read_data_o);
        check_field("ack_error", 8'(want.ack_error), 8'(ack_error_o));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        out_ready_i = 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        stall_left  = pick_gap();
      end
    end
  end

  // Reset timing: one ack wait at 250 ticks per phase, acked inside the poll limit.
  task automatic test_reset_timing();
    issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 2, 1'b0);
  endtask

  task automatic test_directed();
    set_timing(16'd2, 8'd3);
    issue(i2cbb_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
    issue(i2cbb_pkg::CMD_WRITE, 8'hFF, 1'b0, 0, 1'b1);
    issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
    issue(i2cbb_pkg::CMD_WRITE, 8'h00, 1'b0, 0, 1'b0);
    // ack arrives on the last poll before the limit
    issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 3, 1'b0);
    issue(i2cbb_pkg::CMD_WRITE, 8'hA5, 1'b1, 0, 1'b1);
    // one poll too many: abort with stop and error
    issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 4, 1'b1);
    issue(i2cbb_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
    issue(i2cbb_pkg::CMD_READ, 8'h00, 1'b1, 0, 1'b1);
    issue(i2cbb_pkg::CMD_READ, 8'hFF, 1'b0, 0, 1'b0);
    for (int c = int'(i2cbb_pkg::CMD_READ) + 1; c <= CmdCodeMax; c++)
      issue(3'(c), 8'h5A, 1'b1, 0, 1'b0);
    issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 1, 1'b0);
    issue(i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b1);
  endtask

  task automatic test_timing_extremes();
    for (int k = 0; k < 2; k++) begin
      // zero phase length runs as one; zero timeout aborts on the first high poll
      set_timing(16'(k), 8'(k));
      issue(i2cbb_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
      issue(i2cbb_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, 0, 1'b1);
      issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, k + 1, 1'b0);
      issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
      issue(i2cbb_pkg::CMD_READ, 8'h00, 1'b1, 0, 1'b1);
      issue(i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
    end
    // widest timeout with a prompt ack
    set_timing(16'd1, 8'd255);
    issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 7, 1'b1);
  endtask

  task automatic test_backpressure();
    set_timing(16'd1, 8'd4);
    hold_len = ReadyHoldCycles;
    issue(i2cbb_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
    issue(i2cbb_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, 0, 1'b1);
    issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 2, 1'b0);
    issue(i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int nbytes;
    int ack_after;
    stop_at = ticks_sent + RandTicks;
    while (ticks_sent < stop_at) begin
      case ($urandom_range(0, 4))
        0:       set_timing(16'($urandom_range(0, 2)), 8'($urandom_range(0, 6)));
        1:       set_timing(16'($urandom_range(1, 4)), 8'($urandom_range(0, 3)));
        default: ;
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        // noise: stray ticks or a lone command, possibly an unused code
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 6)) send_tick(rand_tick());
        end else begin
          issue(3'($urandom_range(0, CmdCodeMax)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), int'($urandom_range(0, 8)),
                1'($urandom_range(0, 1)));
        end
      end else begin
        issue(i2cbb_pkg::CMD_START, 8'h00, 1'b0, 0, 1'($urandom_range(0, 1)));
        issue(i2cbb_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, 0,
              1'($urandom_range(0, 1)));
        ack_after = ($urandom_range(0, 6) == 0) ? int'(cfg_ack_timeout) + 1 :
                    int'($urandom_range(0, cfg_ack_timeout));
        issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, ack_after, 1'($urandom_range(0, 1)));
        if (!ack_err) begin
          nbytes = $urandom_range(1, 3);
          for (int b = 0; b < nbytes; b++) begin
            if ($urandom_range(0, 1)) begin
              issue(i2cbb_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, 0,
                    1'($urandom_range(0, 1)));
              issue(i2cbb_pkg::CMD_WAIT_ACK, 8'h00, 1'b0,
                    int'($urandom_range(0, int'(cfg_ack_timeout) + 1)),
                    1'($urandom_range(0, 1)));
            end else begin
              issue(i2cbb_pkg::CMD_READ, 8'h00, b != nbytes - 1, 0,
                    1'($urandom_range(0, 1)));
            end
          end
          issue(i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'($urandom_range(0, 1)));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    cmd_valid_i     = 1'b0;
    command_i       = i2cbb_pkg::CMD_START;
    write_data_i    = 8'h00;
    send_ack_i      = 1'b0;
    sda_in_i        = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = ADDR_PHASE_TICKS;
    pwdata          = 32'h0;
    cfg_phase_ticks = i2cbb_pkg::PHASE_TICKS_RESET;
    cfg_ack_timeout = i2cbb_pkg::ACK_TIMEOUT_RESET;
    eng_phase       = i2cbb_pkg::PH_IDLE;
    bit_idx         = '0;
    shift_q         = '0;
    phase_cnt       = '0;
    wait_cnt        = '0;
    pin_scl         = 1'b1;
    pin_sda         = 1'b1;
    pin_drv         = 1'b1;
    ack_err         = 1'b0;
    ack_pick        = 1'b0;
    rx_byte         = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_timing();
    test_directed();
    test_timing_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) $display("i2c_bitbang_master_tb: done, clean");
    else $display("i2c_bitbang_master_tb: done, errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("i2c_bitbang_master_tb: done, errors");
    $finish;
  end

endmodule

// ----- i2c_bitbang_master.f -----
+incdir+design
design/i2cbb_pkg.sv
design/i2cbb_front.sv
design/i2cbb_engine.sv
design/i2c_bitbang_master.sv
design/i2cbb_checker.sv
dv/i2c_bitbang_master_tb.sv
